// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define TSBC_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define TSBC_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

// ===== hdl/tsbc_pkg.sv =====
package tsbc_pkg;

  localparam int PAIR_CLASSES_DEF = 3;
  localparam int CELLS_FIRST_DEF  = 4;
  localparam int CELLS_SECOND_DEF = 4;
  localparam int CELLS_CONJ_DEF   = 9;
  localparam int COEF_BITS_DEF    = 40;

  localparam int TERMS          = 64;
  localparam int OUTS           = 4;
  localparam int AXES           = 3;
  localparam int COORD_W        = 20;
  localparam int FRAC_W         = 16;
  localparam int FACT_W         = 18;
  localparam int XY_W           = 2 * FACT_W;
  localparam int XYZ_W          = XY_W + FACT_W;
  localparam int HALF_W         = 32;
  localparam int MAG_W          = 2 * HALF_W;
  localparam int HP_W           = HALF_W + FACT_W;
  localparam int OUT_W          = 48;
  localparam int TERM_W         = OUT_W + 1;
  localparam int ADDS_PER_STAGE = 4;
  localparam int ACC_STAGES     = TERMS / ADDS_PER_STAGE;

  localparam logic [FACT_W-1:0] ONE_Q16 = FACT_W'(65536);
  localparam logic [TERM_W-1:0] TERM_LIM = {2'b01, {(TERM_W-2){1'b0}}};
  localparam logic signed [OUT_W-1:0] SAT_POS = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] SAT_NEG = {1'b1, {(OUT_W-1){1'b0}}};

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_EVAL  = 1'b1
  } req_kind_t;

  typedef logic [FACT_W-1:0] fact_t;

  typedef struct packed {
    fact_t [3:0] p;
    fact_t [3:0] d;
  } factors_t;

  function automatic logic signed [TERM_W-1:0] term_of(input logic [HP_W-1:0] hp,
                                                       input logic [HP_W-1:0] lp,
                                                       input logic neg);
    logic [TERM_W-1:0] t;
    logic [HP_W-1:0] lr;
    lr = lp + HP_W'(32768);
    if (hp >= HP_W'(64'h8000_0000)) begin
      t = TERM_LIM;
    end else begin
      t = TERM_W'({hp[HALF_W-2:0], 16'h0000}) + TERM_W'(lr >> 16);
      if (t > TERM_LIM) begin
        t = TERM_LIM;
      end
    end
    return neg ? -$signed(t) : $signed(t);
  endfunction

  function automatic logic signed [OUT_W-1:0] sat_add(input logic signed [OUT_W-1:0] a,
                                                      input logic signed [TERM_W-1:0] b);
    logic signed [OUT_W+1:0] s;
    s = (OUT_W+2)'(a) + (OUT_W+2)'(b);
    if (s > (OUT_W+2)'(SAT_POS)) begin
      return SAT_POS;
    end else if (s < (OUT_W+2)'(SAT_NEG)) begin
      return SAT_NEG;
    end
    return s[OUT_W-1:0];
  endfunction

endpackage

// ===== hdl/tsbc_if.sv =====
interface tsbc_req_if #(parameter int COEF_BITS = tsbc_pkg::COEF_BITS_DEF);
  import tsbc_pkg::*;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [1:0]                  atom_type_i;
  logic [1:0]                  atom_type_j;
  logic [2:0]                  cell_first;
  logic [2:0]                  cell_second;
  logic [3:0]                  cell_third;
  logic [5:0]                  term_index;
  logic signed [COEF_BITS-1:0] coef_value;
  logic [COORD_W-1:0]          coord_first;
  logic [COORD_W-1:0]          coord_second;
  logic [COORD_W-1:0]          coord_conj;
  modport source (output valid, req_type, atom_type_i, atom_type_j, cell_first, cell_second,
                  cell_third, term_index, coef_value, coord_first, coord_second, coord_conj,
                  input ready);
  modport sink (input valid, req_type, atom_type_i, atom_type_j, cell_first, cell_second,
                cell_third, term_index, coef_value, coord_first, coord_second, coord_conj,
                output ready);
endinterface

interface tsbc_res_if;
  import tsbc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] spline_value;
  logic signed [OUT_W-1:0] deriv_first;
  logic signed [OUT_W-1:0] deriv_second;
  logic signed [OUT_W-1:0] deriv_conj;
  modport source (output valid, spline_value, deriv_first, deriv_second, deriv_conj,
                  input ready);
  modport sink (input valid, spline_value, deriv_first, deriv_second, deriv_conj,
                output ready);
endinterface

// ===== hdl/tsbc_ram.sv =====
module tsbc_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 432,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== hdl/tsbc_powers.sv =====
module tsbc_powers (
  input  logic                     clk,
  input  logic                     en,
  input  logic [tsbc_pkg::FRAC_W-1:0] frac,
  output tsbc_pkg::factors_t       fac
);
  import tsbc_pkg::*;

  logic [FRAC_W-1:0]   f1;
  logic [2*FRAC_W-1:0] sq1;
  logic [FRAC_W-1:0]   f2;
  logic [FRAC_W-1:0]   p2;
  logic [3*FRAC_W-1:0] cube2;

  always_ff @(posedge clk) begin
    if (en) begin
      f1    <= frac;
      sq1   <= (2*FRAC_W)'(frac) * (2*FRAC_W)'(frac);
      f2    <= f1;
      p2    <= FRAC_W'((sq1 + (2*FRAC_W)'(32768)) >> 16);
      cube2 <= (3*FRAC_W)'(sq1) * (3*FRAC_W)'(f1);
      fac.p[0] <= ONE_Q16;
      fac.p[1] <= FACT_W'(f2);
      fac.p[2] <= FACT_W'(p2);
      fac.p[3] <= FACT_W'((cube2 + (3*FRAC_W)'(64'h8000_0000)) >> 32);
      fac.d[0] <= '0;
      fac.d[1] <= ONE_Q16;
      fac.d[2] <= FACT_W'({f2, 1'b0});
      fac.d[3] <= FACT_W'({p2, 1'b0}) + FACT_W'(p2);
    end
  end

endmodule

// ===== hdl/tricubic_spline_bond_correction.sv =====
// Tricubic spline evaluator with a writable coefficient store.
// Input channel req: a write item (req_type 0) stores one coefficient of one
// cell and gives no result; an evaluate item (req_type 1) gives one result on
// channel res with the value and three partial derivatives in signed Q28.20.
// The store is 64 RAMs, one per polynomial term, each holding one coefficient
// for every pair class and cell, so one read fetches a whole cell.
// Results are presented in the order their items were accepted. One item
// may be accepted in every cycle while the pipeline is not held; the wide read
// fetches a whole cell at once; there are 23 register stages (wide read, powers,
// weights, products, and sixteen stages of four saturating additions each).
// Reset clears the pipeline valid bits only; the coefficient store keeps its
// content and must be written before a cell is evaluated.
// When the receiver holds res.ready low with a result waiting, the whole
// pipeline holds and req.ready falls in the same cycle; nothing is lost or
// repeated.
`include "assert_macros.svh"

module tricubic_spline_bond_correction #(
  parameter int PAIR_CLASSES = tsbc_pkg::PAIR_CLASSES_DEF,
  parameter int CELLS_FIRST  = tsbc_pkg::CELLS_FIRST_DEF,
  parameter int CELLS_SECOND = tsbc_pkg::CELLS_SECOND_DEF,
  parameter int CELLS_CONJ   = tsbc_pkg::CELLS_CONJ_DEF,
  parameter int COEF_BITS    = tsbc_pkg::COEF_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  tsbc_req_if.sink   req,
  tsbc_res_if.source res
);
  import tsbc_pkg::*;

  localparam int DEPTH = PAIR_CLASSES * CELLS_FIRST * CELLS_SECOND * CELLS_CONJ;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NSTG  = 7 + ACC_STAGES;
  localparam int LAST  = NSTG - 1;

  function automatic logic [4:0] clamp_cell(input logic [COORD_W-1:0] c, input int top);
    int ip;
    ip = int'(c[COORD_W-1:FRAC_W]);
    if (ip < 1) begin
      return 5'd1;
    end else if (ip >= top) begin
      return 5'(top);
    end
    return 5'(ip);
  endfunction

  function automatic logic [FRAC_W-1:0] clamp_frac(input logic [COORD_W-1:0] c, input int top);
    int ip;
    ip = int'(c[COORD_W-1:FRAC_W]);
    if (ip < 1 || ip >= top) begin
      return '0;
    end
    return c[FRAC_W-1:0];
  endfunction

  logic            adv;
  logic            accept;
  logic [NSTG-1:0] vld;
  logic [2:0]      pair_sum;
  logic            cls_ok;
  logic [1:0]      cls;
  logic [4:0]      cl, cm, cn;
  logic            wr_ok;
  logic [AW-1:0]   addr;
  logic [FRAC_W-1:0] frac [AXES];
  logic            cls_ok0;

  logic [COEF_BITS-1:0] rdata [TERMS];
  logic [MAG_W-1:0]     mag1 [TERMS];
  logic [MAG_W-1:0]     mag2 [TERMS];
  logic [MAG_W-1:0]     mag3 [TERMS];
  logic [MAG_W-1:0]     mag4 [TERMS];
  logic                 neg1 [TERMS];
  logic                 neg2 [TERMS];
  logic                 neg3 [TERMS];
  logic                 neg4 [TERMS];
  logic                 neg5 [TERMS];
  factors_t             fac2 [AXES];
  logic [XY_W-1:0]      xy3 [TERMS][OUTS];
  logic [FACT_W-1:0]    z3  [TERMS][OUTS];
  logic [FACT_W-1:0]    w4  [TERMS][OUTS];
  logic [HP_W-1:0]      hp5 [TERMS][OUTS];
  logic [HP_W-1:0]      lp5 [TERMS][OUTS];
  logic signed [TERM_W-1:0] termp [ACC_STAGES+1][TERMS][OUTS];
  logic signed [OUT_W-1:0]  accp  [ACC_STAGES+1][OUTS];

  assign adv       = !vld[LAST] || res.ready;
  assign accept    = req.valid && adv;
  assign req.ready = adv;
  assign res.valid = vld[LAST];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTG-2:0], accept && (req.req_type == REQ_EVAL)};
    end
  end

  always_comb begin
    pair_sum = 3'(req.atom_type_i) + 3'(req.atom_type_j);
    cls_ok   = (pair_sum >= 3'd2) && ((int'(pair_sum) - 2) < PAIR_CLASSES);
    cls      = cls_ok ? 2'(pair_sum - 3'd2) : 2'd0;
    if (req.req_type == REQ_WRITE) begin
      cl = 5'(req.cell_first);
      cm = 5'(req.cell_second);
      cn = 5'(req.cell_third);
    end else begin
      cl = clamp_cell(req.coord_first, CELLS_FIRST);
      cm = clamp_cell(req.coord_second, CELLS_SECOND);
      cn = clamp_cell(req.coord_conj, CELLS_CONJ);
    end
    wr_ok = cls_ok && cl >= 5'd1 && int'(cl) <= CELLS_FIRST && cm >= 5'd1 &&
            int'(cm) <= CELLS_SECOND && cn >= 5'd1 && int'(cn) <= CELLS_CONJ;
    addr = AW'((((int'(cls) * CELLS_FIRST + int'(cl) - 1) * CELLS_SECOND + int'(cm) - 1)
               * CELLS_CONJ) + int'(cn) - 1);
    frac[0] = clamp_frac(req.coord_first, CELLS_FIRST);
    frac[1] = clamp_frac(req.coord_second, CELLS_SECOND);
    frac[2] = clamp_frac(req.coord_conj, CELLS_CONJ);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cls_ok0 <= cls_ok;
    end
  end

  for (genvar a = 0; a < AXES; a++) begin : g_axis
    tsbc_powers u_powers (
      .clk  (clk),
      .en   (adv),
      .frac (frac[a]),
      .fac  (fac2[a])
    );
  end

  for (genvar t = 0; t < TERMS; t++) begin : g_term
    logic [MAG_W-1:0] c64;

    tsbc_ram #(.WIDTH(COEF_BITS), .DEPTH(DEPTH)) u_ram (
      .clk   (clk),
      .we    (accept && (req.req_type == REQ_WRITE) && wr_ok && (req.term_index == 6'(t))),
      .re    (adv),
      .addr  (addr),
      .wdata (req.coef_value),
      .rdata (rdata[t])
    );

    assign c64 = cls_ok0 ? MAG_W'($signed(rdata[t])) : '0;

    always_ff @(posedge clk) begin
      if (adv) begin
        neg1[t] <= c64[MAG_W-1];
        mag1[t] <= c64[MAG_W-1] ? -c64 : c64;
        neg2[t] <= neg1[t];
        mag2[t] <= mag1[t];
        neg3[t] <= neg2[t];
        mag3[t] <= mag2[t];
        neg4[t] <= neg3[t];
        mag4[t] <= mag3[t];
        neg5[t] <= neg4[t];
      end
    end

    for (genvar o = 0; o < OUTS; o++) begin : g_out
      logic [FACT_W-1:0] x, y;
      logic [XYZ_W-1:0]  xyz;

      assign x   = (o == 1) ? fac2[0].d[t/16] : fac2[0].p[t/16];
      assign y   = (o == 2) ? fac2[1].d[(t/4)%4] : fac2[1].p[(t/4)%4];
      assign xyz = XYZ_W'(xy3[t][o]) * XYZ_W'(z3[t][o]) + XYZ_W'(64'h8000_0000);

      always_ff @(posedge clk) begin
        if (adv) begin
          xy3[t][o] <= XY_W'(x) * XY_W'(y);
          z3[t][o]  <= (o == 3) ? fac2[2].d[t%4] : fac2[2].p[t%4];
          w4[t][o]  <= FACT_W'(xyz >> 32);
          hp5[t][o] <= HP_W'(mag4[t][MAG_W-1:HALF_W]) * HP_W'(w4[t][o]);
          lp5[t][o] <= HP_W'(mag4[t][HALF_W-1:0]) * HP_W'(w4[t][o]);
          termp[0][t][o] <= term_of(hp5[t][o], lp5[t][o], neg5[t]);
        end
      end
    end
  end

  for (genvar o = 0; o < OUTS; o++) begin : g_acc0
    always_ff @(posedge clk) begin
      if (adv) begin
        accp[0][o] <= '0;
      end
    end
  end

  for (genvar j = 1; j <= ACC_STAGES; j++) begin : g_acc
    for (genvar o = 0; o < OUTS; o++) begin : g_out
      logic signed [OUT_W-1:0] sum;

      always_comb begin
        sum = accp[j-1][o];
        for (int k = 0; k < ADDS_PER_STAGE; k++) begin
          sum = sat_add(sum, termp[j-1][(j-1)*ADDS_PER_STAGE+k][o]);
        end
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          accp[j][o] <= sum;
        end
      end

      for (genvar t = 0; t < TERMS; t++) begin : g_pass
        always_ff @(posedge clk) begin
          if (adv) begin
            termp[j][t][o] <= termp[j-1][t][o];
          end
        end
      end
    end
  end

  assign res.spline_value = accp[ACC_STAGES][0];
  assign res.deriv_first  = accp[ACC_STAGES][1];
  assign res.deriv_second = accp[ACC_STAGES][2];
  assign res.deriv_conj   = accp[ACC_STAGES][3];

  `TSBC_ASSERT_NEXT(a_write_no_result, accept && (req.req_type == REQ_WRITE), !vld[0], "write item entered the result pipeline")
  `TSBC_ASSERT_NEXT(a_hold_on_stall, !adv, $stable(vld), "pipeline moved while stalled")
  `TSBC_ASSERT_NEXT(a_stage_advance, vld[0] && adv, vld[1], "item lost between first stages")

endmodule
